[rtl/dfa_pkg.sv]
// ----------------------------------------------------------------------------
// dfa_pkg: shared types and constants for the DFA word acceptor
//
// Item and result formats, table geometry, item and result codes, sequencer
// states and the edge table request and response structs.
// ----------------------------------------------------------------------------
package dfa_pkg;

    localparam int NUM_STATES = 16;
    localparam int ST_W       = 4;                         // state field width
    localparam int SYM_W      = 8;
    localparam int IDX_W      = (NUM_STATES > 1) ? $clog2(NUM_STATES) : 1;
    localparam int CNT_W      = IDX_W + 1;                 // holds NUM_STATES itself
    localparam int TBL_DEPTH  = NUM_STATES * NUM_STATES;
    localparam int ADDR_W     = $clog2(TBL_DEPTH);

    localparam logic [1:0] KIND_EDGE   = 2'd0;
    localparam logic [1:0] KIND_FINAL  = 2'd1;
    localparam logic [1:0] KIND_SYMBOL = 2'd2;
    localparam logic [1:0] KIND_END    = 2'd3;

    localparam logic RES_STEP    = 1'b0;
    localparam logic RES_VERDICT = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [ST_W-1:0]  from_state;
        logic [ST_W-1:0]  to_state;
        logic [SYM_W-1:0] symbol;
        logic             is_final;
    } in_item_t;

    typedef struct packed {
        logic             result_kind;
        logic [ST_W-1:0]  path_state;
        logic             dead;
        logic             accepted;
    } out_item_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
        logic [SYM_W-1:0]  label;
    } edge_wr_t;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr;
    } edge_rd_req_t;

    typedef struct packed {
        logic             valid;
        logic [SYM_W-1:0] label;
    } edge_rd_t;

endpackage

[rtl/dfa_ram.sv]
// ----------------------------------------------------------------------------
// dfa_ram: generic single-port-write, single-port-read RAM
//
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module dfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/dfa_edge_tbl.sv]
// ----------------------------------------------------------------------------
// dfa_edge_tbl: transition table of edge labels with per-entry valid bits
//
// Labels sit in RAM; valid bits sit in flops that reset clears, so an entry
// that was never written reads as no edge. Read data is registered.
// ----------------------------------------------------------------------------
module dfa_edge_tbl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  dfa_pkg::edge_wr_t     wr,
    input  dfa_pkg::edge_rd_req_t rd_req,
    output dfa_pkg::edge_rd_t     rd
);

    logic [dfa_pkg::TBL_DEPTH-1:0] valid_reg;
    logic                          rd_valid_reg;
    logic [dfa_pkg::SYM_W-1:0]     rd_label;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr.en) begin
            valid_reg[wr.addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_req.en) begin
            rd_valid_reg <= valid_reg[rd_req.addr];
        end
    end

    dfa_ram #(
        .WIDTH (dfa_pkg::SYM_W),
        .DEPTH (dfa_pkg::TBL_DEPTH)
    ) u_label_ram (
        .aclk    (aclk),
        .wr_en   (wr.en),
        .wr_addr (wr.addr),
        .wr_data (wr.label),
        .rd_en   (rd_req.en),
        .rd_addr (rd_req.addr),
        .rd_data (rd_label)
    );

    assign rd.valid = rd_valid_reg;
    assign rd.label = rd_label;

endmodule

[rtl/dfa_word_acceptor.sv]
// ----------------------------------------------------------------------------
// dfa_word_acceptor: finite automaton acceptor with a loadable edge table
//
// Items write an edge, mark a final state, feed one word symbol or end the
// word. A symbol scans the current state's row for the lowest target whose
// edge carries it; end of word reports the verdict and restarts the word.
// ----------------------------------------------------------------------------
//
//   channel  dir  ports                         payload
//   -------  ---  ----------------------------  ------------------------------
//   input    in   s_valid / s_ready / s_data    kind, from/to state, symbol, final
//   result   out  m_valid / m_ready / m_data    result kind, path state, dead, verdict
//   config   in   cfg_valid / cfg_ready / data  start_state (4 bits)
//
// Edge writes and final marks are done when taken, in the idle step; end of word
// goes through the emit step. A symbol scans the row with one compare per row entry in the
// shared label compare, set by the single read port of the edge table RAM.
// Reset clears the edge valid bits and the final set at once; no sweep.
// A result waiting on m_ready does not block new items until the next result
// is ready to leave; the sequencer then holds in its emit step.
// ----------------------------------------------------------------------------
module dfa_word_acceptor (
    input  logic               aclk,
    input  logic               aresetn,

    input  logic               s_valid,
    output logic               s_ready,
    input  dfa_pkg::in_item_t  s_data,

    output logic               m_valid,
    input  logic               m_ready,
    output dfa_pkg::out_item_t m_data,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [3:0]         cfg_data
);

    dfa_pkg::state_t                state_reg, state_next;
    logic [dfa_pkg::ST_W-1:0]       start_reg;
    logic [dfa_pkg::ST_W-1:0]       cur_reg, cur_next;
    logic                           dead_reg, dead_next;
    logic [dfa_pkg::NUM_STATES-1:0] final_reg, final_next;
    logic [dfa_pkg::SYM_W-1:0]      sym_reg, sym_next;
    logic [dfa_pkg::CNT_W-1:0]      issue_reg, issue_next;
    logic [dfa_pkg::IDX_W-1:0]      cmp_idx_reg, cmp_idx_next;
    logic                           cmp_vld_reg, cmp_vld_next;
    dfa_pkg::out_item_t             res_reg, res_next;
    logic                           m_valid_reg, m_valid_next;
    dfa_pkg::out_item_t             m_data_reg, m_data_next;

    dfa_pkg::edge_wr_t              tbl_wr;
    dfa_pkg::edge_rd_req_t          tbl_rd_req;
    dfa_pkg::edge_rd_t              tbl_rd;

    logic                           s_xfer;
    logic                           cur_ok;
    logic                           cur_final;
    logic                           match;
    logic                           row_done;

    assign s_ready   = (state_reg == dfa_pkg::ST_IDLE);
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    assign cur_ok    = int'(cur_reg) < dfa_pkg::NUM_STATES;
    assign cur_final = cur_ok && final_reg[dfa_pkg::IDX_W'(cur_reg)];

    // The shared compare: table entry returned this cycle against the symbol.
    assign match     = cmp_vld_reg && tbl_rd.valid && (tbl_rd.label == sym_reg);
    assign row_done  = cmp_vld_reg &&
                       (int'(cmp_idx_reg) == dfa_pkg::NUM_STATES - 1);

    dfa_edge_tbl u_edge_tbl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr      (tbl_wr),
        .rd_req  (tbl_rd_req),
        .rd      (tbl_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= dfa_pkg::ST_IDLE;
            start_reg   <= '0;
            cur_reg     <= '0;
            dead_reg    <= 1'b0;
            final_reg   <= '0;
            issue_reg   <= '0;
            cmp_vld_reg <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            if (cfg_valid && cfg_ready) begin
                start_reg <= cfg_data;
            end
            cur_reg     <= cur_next;
            dead_reg    <= dead_next;
            final_reg   <= final_next;
            issue_reg   <= issue_next;
            cmp_vld_reg <= cmp_vld_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers: no reset.
    always_ff @(posedge aclk) begin
        sym_reg     <= sym_next;
        cmp_idx_reg <= cmp_idx_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
    end

    always_comb begin
        state_next   = state_reg;
        cur_next     = cur_reg;
        dead_next    = dead_reg;
        final_next   = final_reg;
        sym_next     = sym_reg;
        issue_next   = issue_reg;
        cmp_idx_next = cmp_idx_reg;
        cmp_vld_next = 1'b0;
        res_next     = res_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;

        tbl_wr.en     = 1'b0;
        tbl_wr.addr   = dfa_pkg::ADDR_W'(int'(s_data.from_state) * dfa_pkg::NUM_STATES
                                         + int'(s_data.to_state));
        tbl_wr.label  = s_data.symbol;
        tbl_rd_req.en   = 1'b0;
        tbl_rd_req.addr = dfa_pkg::ADDR_W'(int'(cur_reg) * dfa_pkg::NUM_STATES
                                           + int'(issue_reg[dfa_pkg::IDX_W-1:0]));

        unique case (state_reg)
            dfa_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    unique case (s_data.kind)
                        dfa_pkg::KIND_EDGE: begin
                            // Drop edges that name a state outside the table.
                            tbl_wr.en = (int'(s_data.from_state) < dfa_pkg::NUM_STATES) &&
                                        (int'(s_data.to_state) < dfa_pkg::NUM_STATES);
                        end
                        dfa_pkg::KIND_FINAL: begin
                            if (int'(s_data.from_state) < dfa_pkg::NUM_STATES) begin
                                final_next[dfa_pkg::IDX_W'(s_data.from_state)] =
                                    s_data.is_final;
                            end
                        end
                        dfa_pkg::KIND_SYMBOL: begin
                            res_next.result_kind = dfa_pkg::RES_STEP;
                            res_next.path_state  = cur_reg;
                            res_next.dead        = 1'b1;
                            res_next.accepted    = 1'b0;
                            if (dead_reg) begin
                                state_next = dfa_pkg::ST_EMIT;
                            end else if (!cur_ok) begin
                                // No row to scan: the word dies here.
                                dead_next  = 1'b1;
                                state_next = dfa_pkg::ST_EMIT;
                            end else begin
                                sym_next   = s_data.symbol;
                                issue_next = '0;
                                state_next = dfa_pkg::ST_SCAN;
                            end
                        end
                        dfa_pkg::KIND_END: begin
                            res_next.result_kind = dfa_pkg::RES_VERDICT;
                            res_next.path_state  = cur_reg;
                            res_next.dead        = dead_reg;
                            res_next.accepted    = !dead_reg && cur_final;
                            cur_next   = start_reg;
                            dead_next  = 1'b0;
                            state_next = dfa_pkg::ST_EMIT;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            dfa_pkg::ST_SCAN: begin
                // Issue the next row entry while comparing the previous one.
                if (int'(issue_reg) < dfa_pkg::NUM_STATES) begin
                    tbl_rd_req.en = 1'b1;
                    cmp_vld_next  = 1'b1;
                    cmp_idx_next  = issue_reg[dfa_pkg::IDX_W-1:0];
                    issue_next    = issue_reg + 1'b1;
                end
                if (match) begin
                    cur_next             = dfa_pkg::ST_W'(cmp_idx_reg);
                    res_next.result_kind = dfa_pkg::RES_STEP;
                    res_next.path_state  = dfa_pkg::ST_W'(cmp_idx_reg);
                    res_next.dead        = 1'b0;
                    res_next.accepted    = 1'b0;
                    cmp_vld_next         = 1'b0;
                    state_next           = dfa_pkg::ST_EMIT;
                end else if (row_done) begin
                    // Hold the state and mark the word dead.
                    dead_next            = 1'b1;
                    res_next.result_kind = dfa_pkg::RES_STEP;
                    res_next.path_state  = cur_reg;
                    res_next.dead        = 1'b1;
                    res_next.accepted    = 1'b0;
                    cmp_vld_next         = 1'b0;
                    state_next           = dfa_pkg::ST_EMIT;
                end
            end

            dfa_pkg::ST_EMIT: begin
                // Advance the result into the output register once it is free.
                if (!m_valid_reg || m_ready) begin
                    m_data_next  = res_reg;
                    m_valid_next = 1'b1;
                    state_next   = dfa_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = dfa_pkg::ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
    a_match_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dfa_pkg::ST_SCAN && match) |=> (state_reg == dfa_pkg::ST_EMIT))
        else $error("scan hit did not move to emit");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == dfa_pkg::ST_SCAN) |-> (int'(issue_reg) <= dfa_pkg::NUM_STATES))
        else $error("row scan issued past the end of the row");

    a_step_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_data_reg.accepted &&
                          (m_data_reg.dead || m_data_reg.result_kind == dfa_pkg::RES_STEP)))
        else $error("accepted flag set on a step or a dead word");

    a_edge_one_cycle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && (s_data.kind == dfa_pkg::KIND_EDGE || s_data.kind == dfa_pkg::KIND_FINAL))
        |=> (state_reg == dfa_pkg::ST_IDLE && $stable(m_valid_reg) || $past(m_ready)))
        else $error("table update did not complete in one cycle");

endmodule

[dv/tb_dfa_word_acceptor.sv]
// ----------------------------------------------------------------------------
// tb_dfa_word_acceptor: self-checking bench for the DFA word acceptor
//
// Loads edges and final marks, feeds words and checks every path step and
// verdict against an in-bench automaton tracked at each input transfer.
// Random bursts on the input, a shifting stall pattern on the result side and
// a long result hold-off exercise back-pressure; start_state moves per phase.
// ----------------------------------------------------------------------------
module tb_dfa_word_acceptor;

    localparam int IDLE_LIMIT    = 2000;                    // cycles without any transfer
    localparam int SETTLE_CYCLES = dfa_pkg::NUM_STATES + 8; // worst symbol scan plus margin
    localparam int PHASE_ITEMS   = 300;
    localparam int HOLD_CYCLES   = 300;

    logic               aclk      = 1'b0;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    dfa_pkg::in_item_t  s_data    = '0;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    dfa_pkg::out_item_t m_data;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [3:0]         cfg_data  = '0;

    dfa_word_acceptor u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Automaton tracked by the bench: {valid, label} per (from, to) pair,
    // final marks, the walk position and the dead flag of the current word.
    // ------------------------------------------------------------------------
    logic [dfa_pkg::SYM_W:0]  edge_lbl   [dfa_pkg::NUM_STATES][dfa_pkg::NUM_STATES];
    logic                     final_mark [dfa_pkg::NUM_STATES];
    logic [dfa_pkg::ST_W-1:0] cur_st;
    logic [dfa_pkg::ST_W-1:0] start_st;
    logic                     word_dead_m;

    dfa_pkg::in_item_t  pending_items [$];   // items not yet offered on the input
    dfa_pkg::out_item_t path_verdict_q [$];  // steps and verdicts still owed by the block
    bit                 item_on_wire = 1'b0; // an item is offered and not yet taken
    int                 mismatch_count = 0;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR @%0t %s: got %0d, expected %0d", $time, what, got, want);
        mismatch_count++;
    endtask

    // Apply one accepted item to the automaton and queue the result it owes.
    task automatic advance_automaton(input dfa_pkg::in_item_t it);
        dfa_pkg::out_item_t       res;
        logic [dfa_pkg::ST_W-1:0] row;
        bit                       found;
        res   = '0;
        row   = cur_st;
        found = 1'b0;
        case (it.kind)
            dfa_pkg::KIND_EDGE: begin
                edge_lbl[it.from_state][it.to_state] = {1'b1, it.symbol};
            end
            dfa_pkg::KIND_FINAL: begin
                final_mark[it.from_state] = it.is_final;
            end
            dfa_pkg::KIND_SYMBOL: begin
                // Scan the row from target 0; the lowest matching target wins.
                if (!word_dead_m) begin
                    for (int j = 0; j < dfa_pkg::NUM_STATES; j++) begin
                        if (!found && edge_lbl[row][j][dfa_pkg::SYM_W] &&
                            edge_lbl[row][j][dfa_pkg::SYM_W-1:0] == it.symbol) begin
                            cur_st = j[dfa_pkg::ST_W-1:0];
                            found  = 1'b1;
                        end
                    end
                    // No edge: the word dies and the state holds.
                    if (!found) word_dead_m = 1'b1;
                end
                res.result_kind = dfa_pkg::RES_STEP;
                res.path_state  = cur_st;
                res.dead        = word_dead_m;
                res.accepted    = 1'b0;
                path_verdict_q.push_back(res);
            end
            default: begin
                res.result_kind = dfa_pkg::RES_VERDICT;
                res.path_state  = cur_st;
                res.dead        = word_dead_m;
                res.accepted    = !word_dead_m && final_mark[cur_st];
                path_verdict_q.push_back(res);
                cur_st      = start_st;
                word_dead_m = 1'b0;
            end
        endcase
    endtask

    // ------------------------------------------------------------------------
    // Input driver: bursts of random length separated by random gaps; a gap
    // of zero gives back-to-back stretches. Hold the payload until taken.
    // ------------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                advance_automaton(s_data);
                item_on_wire = 1'b0;
            end
            if (s_valid && !s_ready) begin
                // hold the offered item
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_items.size() != 0) begin
                s_data       <= pending_items.pop_front();
                s_valid      <= 1'b1;
                item_on_wire = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 40);
                    gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result receiver: switch among stall styles every so often, and twice
    // hold m_ready low for a long stretch so the block backs up its input.
    // ------------------------------------------------------------------------
    int results_taken = 0;
    int hold_left     = 0;
    int style_left    = 0;
    int stall_style   = 0;
    int rx_cycle      = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_cycle++;
            if (style_left == 0) begin
                stall_style = $urandom_range(0, 3);
                style_left  = $urandom_range(64, 256);
            end else begin
                style_left--;
            end
            if (m_valid && m_ready) results_taken++;
            if (hold_left > 0) begin
                hold_left--;
                m_ready <= 1'b0;
            end else if (m_valid && m_ready &&
                         (results_taken == 350 || results_taken == 900)) begin
                hold_left = HOLD_CYCLES;
                m_ready   <= 1'b0;
            end else begin
                case (stall_style)
                    0:       m_ready <= 1'b1;
                    1:       m_ready <= ($urandom_range(0, 9) < 7);
                    2:       m_ready <= (rx_cycle[2:0] != 3'd0);
                    default: m_ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    // Compare every result transfer with the oldest owed result.
    always @(posedge aclk) begin
        dfa_pkg::out_item_t want;
        if (aresetn && m_valid && m_ready) begin
            if (path_verdict_q.size() == 0) begin
                report_mismatch("result with none pending, path_state",
                                int'(m_data.path_state), 0);
            end else begin
                want = path_verdict_q.pop_front();
                if (m_data.result_kind !== want.result_kind)
                    report_mismatch("result_kind", int'(m_data.result_kind),
                                    int'(want.result_kind));
                if (m_data.path_state !== want.path_state)
                    report_mismatch("path_state", int'(m_data.path_state),
                                    int'(want.path_state));
                if (m_data.dead !== want.dead)
                    report_mismatch("dead", int'(m_data.dead), int'(want.dead));
                if (m_data.accepted !== want.accepted)
                    report_mismatch("accepted", int'(m_data.accepted), int'(want.accepted));
            end
        end
    end

    // Watchdog: end the run when no channel moves for too long.
    int idle_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    function automatic dfa_pkg::in_item_t random_item(input logic [1:0] kind);
        dfa_pkg::in_item_t it;
        it            = '0;
        it.kind       = kind;
        it.from_state = 4'($urandom);
        it.to_state   = 4'($urandom);
        it.symbol     = 8'($urandom);
        it.is_final   = 1'($urandom);
        return it;
    endfunction

    task automatic queue_item(input logic [1:0] kind, input logic [3:0] from_s,
                              input logic [3:0] to_s, input logic [7:0] sym,
                              input logic fin);
        dfa_pkg::in_item_t it;
        it            = random_item(kind);
        it.from_state = from_s;
        it.to_state   = to_s;
        it.symbol     = sym;
        it.is_final   = fin;
        pending_items.push_back(it);
    endtask

    task automatic queue_symbol(input logic [7:0] sym);
        dfa_pkg::in_item_t it;
        it        = random_item(dfa_pkg::KIND_SYMBOL);
        it.symbol = sym;
        pending_items.push_back(it);
    endtask

    // One random phase: a small alphabet per phase keeps most words alive,
    // with stray symbols, edge rewrites and final toggles mixed in.
    task automatic queue_random_phase(input int n_items);
        logic [7:0] alpha [4];
        int         count;
        int         pick;
        int         len;
        for (int i = 0; i < 4; i++) alpha[i] = 8'($urandom);
        count = 0;
        repeat (24) begin
            queue_item(dfa_pkg::KIND_EDGE, 4'($urandom), 4'($urandom),
                       alpha[$urandom_range(0, 3)], 1'($urandom));
            count++;
        end
        while (count < n_items) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                queue_item(dfa_pkg::KIND_EDGE, 4'($urandom), 4'($urandom),
                           ($urandom_range(0, 9) == 0) ? 8'($urandom)
                                                       : alpha[$urandom_range(0, 3)],
                           1'($urandom));
                count++;
            end else if (pick < 20) begin
                queue_item(dfa_pkg::KIND_FINAL, 4'($urandom), 4'($urandom),
                           8'($urandom), 1'($urandom));
                count++;
            end else begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 24)
                                                  : $urandom_range(0, 6);
                repeat (len) begin
                    queue_symbol(($urandom_range(0, 15) == 0) ? 8'($urandom)
                                                              : alpha[$urandom_range(0, 3)]);
                end
                // Now and then leave the word open so the next one runs on.
                if ($urandom_range(0, 15) != 0)
                    pending_items.push_back(random_item(dfa_pkg::KIND_END));
                count += len + 1;
            end
        end
        // Half the phases stop mid-word, so the start state moves under a word.
        if ($urandom_range(0, 1) == 1) begin
            queue_symbol(alpha[$urandom_range(0, 3)]);
            queue_symbol(alpha[$urandom_range(0, 3)]);
        end
    endtask

    // Wait for every item to be taken and every owed result to arrive, then
    // give a trailing edge write or final mark time to finish.
    task automatic wait_drained();
        while (pending_items.size() != 0 || item_on_wire || path_verdict_q.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic load_start_state(input logic [3:0] value);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        start_st  = value;
        cfg_valid <= 1'b0;
    endtask

    logic [3:0] phase_start [6];

    initial begin
        for (int f = 0; f < dfa_pkg::NUM_STATES; f++) begin
            final_mark[f] = 1'b0;
            for (int t = 0; t < dfa_pkg::NUM_STATES; t++) edge_lbl[f][t] = '0;
        end
        cur_st      = '0;
        start_st    = '0;
        word_dead_m = 1'b0;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        load_start_state(4'd0);

        // Directed: empty words, dead words, lowest-target priority,
        // edge overwrite, final set and clear, dead word ending on a final state.
        pending_items.push_back(random_item(dfa_pkg::KIND_END)); // empty word, start not final
        queue_symbol(8'h00);                                    // no edges at all: dead
        queue_symbol(8'hFF);                                    // stays dead
        pending_items.push_back(random_item(dfa_pkg::KIND_END));
        queue_item(dfa_pkg::KIND_FINAL, 4'd0, 4'd15, 8'h00, 1'b1);
        pending_items.push_back(random_item(dfa_pkg::KIND_END)); // empty word accepted
        queue_item(dfa_pkg::KIND_EDGE, 4'd0, 4'd15, 8'hFF, 1'b0);
        queue_item(dfa_pkg::KIND_EDGE, 4'd0, 4'd3, 8'hFF, 1'b1);
        queue_item(dfa_pkg::KIND_EDGE, 4'd0, 4'd0, 8'h00, 1'b0);
        queue_symbol(8'hFF);                                    // 3 beats 15
        queue_item(dfa_pkg::KIND_EDGE, 4'd3, 4'd15, 8'h5A, 1'b0);
        queue_item(dfa_pkg::KIND_FINAL, 4'd15, 4'd0, 8'hFF, 1'b1);
        queue_symbol(8'h5A);
        pending_items.push_back(random_item(dfa_pkg::KIND_END)); // accepted in 15
        queue_item(dfa_pkg::KIND_EDGE, 4'd0, 4'd3, 8'h00, 1'b1);  // overwrite label
        queue_symbol(8'h00);                                    // 0 beats 3
        queue_symbol(8'hFF);                                    // only 15 left on FF
        pending_items.push_back(random_item(dfa_pkg::KIND_END));
        queue_item(dfa_pkg::KIND_FINAL, 4'd15, 4'd15, 8'h00, 1'b0);
        queue_symbol(8'hFF);
        pending_items.push_back(random_item(dfa_pkg::KIND_END)); // rejected, alive
        queue_symbol(8'h00);
        queue_symbol(8'h77);                                    // dies in final state 0
        pending_items.push_back(random_item(dfa_pkg::KIND_END)); // rejected
        wait_drained();

        phase_start[0] = 4'd15;
        phase_start[1] = 4'd0;
        phase_start[2] = 4'd9;
        phase_start[3] = 4'($urandom);
        phase_start[4] = 4'd15;
        phase_start[5] = 4'($urandom);
        for (int p = 0; p < 6; p++) begin
            load_start_state(phase_start[p]);
            queue_random_phase(PHASE_ITEMS);
            wait_drained();
        end

        if (mismatch_count == 0 && path_verdict_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
